// ===== rtl/rcn_pkg.sv =====
// ----------------------------------------------------------------------------
// rcn_pkg: shared types and codes of the Raft consensus node
// Beat formats, operation and response codes, roles and sequencer states.
// ----------------------------------------------------------------------------
package rcn_pkg;

	localparam int unsigned LOG_DEPTH_DEF = 1024;

	localparam logic [2:0] OP_VOTE   = 3'd0;
	localparam logic [2:0] OP_HEADER = 3'd1;
	localparam logic [2:0] OP_ENTRY  = 3'd2;
	localparam logic [2:0] OP_CLIENT = 3'd3;
	localparam logic [2:0] OP_TICK   = 3'd4;

	localparam logic [1:0] KIND_VOTE   = 2'd0;
	localparam logic [1:0] KIND_APPEND = 2'd1;
	localparam logic [1:0] KIND_CLIENT = 2'd2;
	localparam logic [1:0] KIND_TICK   = 2'd3;

	localparam logic [1:0] ROLE_FOLLOWER  = 2'd0;
	localparam logic [1:0] ROLE_CANDIDATE = 2'd1;
	localparam logic [1:0] ROLE_LEADER    = 2'd2;

	localparam logic [1:0] ERR_OK         = 2'd0;
	localparam logic [1:0] ERR_LOG_FULL   = 2'd1;
	localparam logic [1:0] ERR_NOT_LEADER = 2'd2;

	localparam logic [1:0] REG_OWN_NODE  = 2'd0;
	localparam logic [1:0] REG_TMO_MIN   = 2'd1;
	localparam logic [1:0] REG_TMO_SPAN  = 2'd2;
	localparam logic [1:0] REG_HEARTBEAT = 2'd3;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] sender;
		logic [31:0] msg_term;
		logic [31:0] ref_log_term;
		logic [31:0] ref_log_index;
		logic [31:0] leader_commit_in;
		logic [10:0] batch_count;
		logic [31:0] entry_term;
		logic [63:0] entry_payload;
		logic [15:0] random_word;
	} in_t;

	typedef struct packed {
		logic [1:0]  resp_kind;
		logic [15:0] resp_to;
		logic [31:0] resp_term;
		logic        granted;
		logic [10:0] match_len;
		logic [1:0]  role_now;
		logic [15:0] known_leader;
		logic [10:0] commit_now;
		logic [1:0]  error_code;
	} out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC
	} state_t;

endpackage

// ===== rtl/rcn_mod.sv =====
// ----------------------------------------------------------------------------
// rcn_mod: iterative remainder unit
// Restoring division, one dividend bit per cycle; a zero divisor gives zero.
// ----------------------------------------------------------------------------
module rcn_mod (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [15:0] divisor,
	output logic        busy,
	output logic [15:0] remainder
);

	logic [15:0] rem_q;
	logic [15:0] shift_q;
	logic [15:0] div_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [16:0] trial;

	assign trial = {rem_q, shift_q[15]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'd16;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= '0;
			shift_q <= dividend;
			div_q   <= divisor;
		end else if (busy_q) begin
			shift_q <= {shift_q[14:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_q <= 16'(trial - {1'b0, div_q});
			end else begin
				rem_q <= trial[15:0];
			end
		end
	end

	assign busy      = busy_q;
	assign remainder = (div_q == 16'd0) ? 16'd0 : rem_q;

endmodule

// ===== rtl/rcn_log_mem.sv =====
// ----------------------------------------------------------------------------
// rcn_log_mem: log entry storage
// Term and payload of each entry, one write port and one registered read.
// ----------------------------------------------------------------------------
module rcn_log_mem #(
	parameter int unsigned LOG_DEPTH = rcn_pkg::LOG_DEPTH_DEF,
	localparam int unsigned AW = $clog2(LOG_DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wterm,
	input  logic [63:0]   wpay,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rterm
);

	logic [31:0] term_mem [LOG_DEPTH];
	logic [63:0] pay_mem  [LOG_DEPTH];
	logic [31:0] rterm_q;

	always_ff @(posedge clk) begin
		if (we) begin
			term_mem[waddr] <= wterm;
			pay_mem[waddr]  <= wpay;
		end
		rterm_q <= term_mem[raddr];
	end

	assign rterm = rterm_q;

endmodule

// ===== rtl/raft_consensus_node_core.sv =====
// ----------------------------------------------------------------------------
// raft_consensus_node_core: Raft follower / candidate node with log
// Handles vote requests, append batches, client appends and ticks.
// ----------------------------------------------------------------------------
// Each input beat passes through the read and execute states after acceptance,
// and the next beat is accepted only once the node is back in idle.
// The shared remainder unit that redraws the election timeout runs on every
// beat and the execute state waits for it; the log memory read overlaps it.
// A new beat is accepted once the previous one is finished, even while its
// result beat still waits in the output register; a later result then waits
// until that beat is taken. No clearing pass is needed after reset.
module raft_consensus_node_core #(
	parameter int unsigned LOG_DEPTH = rcn_pkg::LOG_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rcn_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output rcn_pkg::out_t out_data,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data
);

	localparam int unsigned AW = $clog2(LOG_DEPTH);
	localparam int unsigned LW = $clog2(LOG_DEPTH + 1);
	localparam logic [LW-1:0] DEPTH_L = LW'(LOG_DEPTH);

	rcn_pkg::state_t state_q, state_n;
	rcn_pkg::in_t    in_q;
	rcn_pkg::out_t   out_q, out_n;
	logic            ov_q;

	logic [15:0] own_q, tmin_q, tspan_q, hb_q;
	logic [1:0]  role_q, role_n;
	logic [31:0] term_q, term_n;
	logic [15:0] voted_q, voted_n, leader_q, leader_n;
	logic [LW-1:0] len_q, len_n, commit_q, commit_n;
	logic [31:0] time_q, time_n, beat_q, beat_n;
	logic [16:0] elim_q, elim_n;
	logic        bt_open_q, bt_open_n, bt_ok_q, bt_ok_n, bt_drain_q, bt_drain_n;
	logic [10:0] bt_left_q, bt_left_n;
	logic [31:0] bt_commit_q, bt_commit_n;
	logic [15:0] bt_to_q, bt_to_n;
	logic [32:0] bt_pos_q, bt_pos_n;

	logic          accept, produce, fire, div_busy;
	logic [15:0]   mod_val;
	logic [16:0]   redraw;
	logic [31:0]   rd_term, last_term;
	logic [AW-1:0] raddr;
	logic          we;
	logic [31:0]   wterm;
	logic          vote_free, log_ok, match, ok;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == rcn_pkg::ST_IDLE);
	assign redraw   = {1'b0, tmin_q} + {1'b0, mod_val};

	rcn_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.dividend  (in_data.random_word),
		.divisor   (tspan_q),
		.busy      (div_busy),
		.remainder (mod_val)
	);

	always_comb begin
		case (in_q.op)
			rcn_pkg::OP_VOTE:   raddr = AW'(len_q - LW'(1));
			rcn_pkg::OP_HEADER: raddr = AW'(in_q.ref_log_index - 32'd1);
			default:            raddr = AW'(bt_pos_q);
		endcase
	end

	rcn_log_mem #(.LOG_DEPTH(LOG_DEPTH)) u_log (
		.clk   (clk),
		.we    (we && fire),
		.waddr (AW'(len_n - LW'(1))),
		.wterm (wterm),
		.wpay  (in_q.entry_payload),
		.raddr (raddr),
		.rterm (rd_term)
	);

	always_comb begin
		role_n = role_q; term_n = term_q; voted_n = voted_q; leader_n = leader_q;
		len_n = len_q; commit_n = commit_q; time_n = time_q; beat_n = beat_q;
		elim_n = elim_q; bt_open_n = bt_open_q; bt_ok_n = bt_ok_q;
		bt_drain_n = bt_drain_q; bt_left_n = bt_left_q; bt_commit_n = bt_commit_q;
		bt_to_n = bt_to_q; bt_pos_n = bt_pos_q;
		produce = 1'b0; we = 1'b0; wterm = in_q.entry_term;
		out_n = '0;
		last_term = (len_q == '0) ? 32'd0 : rd_term;
		vote_free = 1'b0; log_ok = 1'b0; match = 1'b0; ok = 1'b0;
		case (in_q.op)
			rcn_pkg::OP_ENTRY: begin
				if (bt_open_q) begin
					bt_pos_n  = bt_pos_q + 33'd1;
					bt_left_n = bt_left_q - 11'd1;
					if (bt_ok_q && !bt_drain_q) begin
						if (bt_pos_q < 33'(len_q) && rd_term != in_q.entry_term) begin
							len_n = LW'(bt_pos_q);
						end
						if (bt_pos_q >= 33'(len_n)) begin
							if (len_n >= DEPTH_L) begin
								bt_drain_n = 1'b1;
								bt_pos_n   = bt_pos_q;
								produce    = 1'b1;
								out_n.resp_kind  = rcn_pkg::KIND_APPEND;
								out_n.resp_to    = bt_to_q;
								out_n.error_code = rcn_pkg::ERR_LOG_FULL;
							end else begin
								we    = 1'b1;
								len_n = len_n + LW'(1);
							end
						end
					end
					if (bt_left_n == 11'd0) begin
						bt_open_n = 1'b0;
					end
					if (!produce && bt_left_n == 11'd0 && !bt_drain_q) begin
						produce = 1'b1;
						out_n.resp_kind = rcn_pkg::KIND_APPEND;
						out_n.resp_to   = bt_to_q;
						if (bt_ok_q) begin
							if (bt_commit_q > 32'(commit_q)) begin
								commit_n = (bt_commit_q > 32'(len_n)) ? len_n
									: LW'(bt_commit_q);
							end
							out_n.granted   = 1'b1;
							out_n.match_len = 11'(len_n);
						end
					end
				end
			end
			rcn_pkg::OP_VOTE: begin
				bt_open_n = 1'b0;
				if (in_q.msg_term > term_q) begin
					role_n = rcn_pkg::ROLE_FOLLOWER; term_n = in_q.msg_term;
					voted_n = '0; leader_n = '0; elim_n = redraw; beat_n = time_q;
				end
				vote_free = (voted_n == '0 || voted_n == in_q.sender)
					&& in_q.msg_term >= term_n;
				log_ok = in_q.ref_log_term > last_term
					|| (in_q.ref_log_term == last_term
					&& in_q.ref_log_index >= 32'(len_q));
				if (vote_free && log_ok && in_q.msg_term == term_n) begin
					voted_n = in_q.sender;
					out_n.granted = 1'b1;
				end
				produce = 1'b1;
				out_n.resp_kind = rcn_pkg::KIND_VOTE;
				out_n.resp_to   = in_q.sender;
			end
			rcn_pkg::OP_HEADER: begin
				if (in_q.msg_term > term_q) begin
					role_n = rcn_pkg::ROLE_FOLLOWER; term_n = in_q.msg_term;
					voted_n = '0; leader_n = '0; elim_n = redraw; beat_n = time_q;
				end
				if (in_q.msg_term == term_n) begin
					if (role_n == rcn_pkg::ROLE_CANDIDATE) begin
						role_n = rcn_pkg::ROLE_FOLLOWER; voted_n = '0;
						elim_n = redraw;
					end
					leader_n = in_q.sender;
					beat_n   = time_q;
				end
				match = (in_q.ref_log_index == 32'd0)
					|| (in_q.ref_log_index <= 32'(len_q)
					&& rd_term == in_q.ref_log_term);
				ok = (in_q.msg_term == term_n) && match;
				if (in_q.batch_count == 11'd0) begin
					bt_open_n = 1'b0;
					produce = 1'b1;
					out_n.resp_kind = rcn_pkg::KIND_APPEND;
					out_n.resp_to   = in_q.sender;
					if (ok) begin
						if (in_q.leader_commit_in > 32'(commit_q)) begin
							commit_n = (in_q.leader_commit_in > 32'(len_q)) ? len_q
								: LW'(in_q.leader_commit_in);
						end
						out_n.granted   = 1'b1;
						out_n.match_len = 11'(len_q);
					end
				end else begin
					bt_open_n = 1'b1; bt_ok_n = ok; bt_drain_n = 1'b0;
					bt_left_n = in_q.batch_count; bt_pos_n = {1'b0, in_q.ref_log_index};
					bt_commit_n = in_q.leader_commit_in; bt_to_n = in_q.sender;
				end
			end
			rcn_pkg::OP_CLIENT: begin
				bt_open_n = 1'b0;
				produce = 1'b1;
				out_n.resp_kind = rcn_pkg::KIND_CLIENT;
				if (role_q != rcn_pkg::ROLE_LEADER) begin
					out_n.error_code = rcn_pkg::ERR_NOT_LEADER;
				end else if (len_q >= DEPTH_L) begin
					out_n.error_code = rcn_pkg::ERR_LOG_FULL;
				end else begin
					we = 1'b1; wterm = term_q;
					len_n = len_q + LW'(1);
					out_n.granted   = 1'b1;
					out_n.match_len = 11'(len_n);
				end
			end
			rcn_pkg::OP_TICK: begin
				bt_open_n = 1'b0;
				time_n = time_q + 32'd1;
				produce = 1'b1;
				out_n.resp_kind = rcn_pkg::KIND_TICK;
				if (role_q != rcn_pkg::ROLE_LEADER) begin
					if (time_n - beat_q > {15'd0, elim_q}) begin
						role_n = rcn_pkg::ROLE_CANDIDATE; term_n = term_q + 32'd1;
						voted_n = own_q; leader_n = '0; elim_n = redraw;
						beat_n = time_n; out_n.granted = 1'b1;
					end
				end else if (time_n - beat_q > {16'd0, hb_q}) begin
					beat_n = time_n; out_n.granted = 1'b1;
				end
			end
			default: begin
			end
		endcase
		out_n.resp_term    = term_n;
		out_n.role_now     = role_n;
		out_n.known_leader = leader_n;
		out_n.commit_now   = 11'(commit_n);
	end

	assign fire = (state_q == rcn_pkg::ST_EXEC) && !div_busy
		&& !(produce && ov_q && !out_ready);

	always_comb begin
		state_n = state_q;
		case (state_q)
			rcn_pkg::ST_IDLE: if (accept) state_n = rcn_pkg::ST_READ;
			rcn_pkg::ST_READ: state_n = rcn_pkg::ST_EXEC;
			rcn_pkg::ST_EXEC: if (fire) state_n = rcn_pkg::ST_IDLE;
			default:          state_n = rcn_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcn_pkg::ST_IDLE;
			ov_q    <= 1'b0;
			own_q <= 16'd1; tmin_q <= 16'd150; tspan_q <= 16'd150; hb_q <= 16'd50;
			role_q <= rcn_pkg::ROLE_FOLLOWER; term_q <= '0; voted_q <= '0;
			leader_q <= '0; len_q <= '0; commit_q <= '0; time_q <= '0;
			beat_q <= '0; elim_q <= 17'd150;
			bt_open_q <= 1'b0; bt_ok_q <= 1'b0; bt_drain_q <= 1'b0;
			bt_left_q <= '0; bt_commit_q <= '0; bt_to_q <= '0; bt_pos_q <= '0;
		end else begin
			state_q <= state_n;
			if (fire && produce) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					rcn_pkg::REG_OWN_NODE:  own_q   <= cfg_data;
					rcn_pkg::REG_TMO_MIN:   tmin_q  <= cfg_data;
					rcn_pkg::REG_TMO_SPAN:  tspan_q <= cfg_data;
					rcn_pkg::REG_HEARTBEAT: hb_q    <= cfg_data;
					default:                hb_q    <= hb_q;
				endcase
			end
			if (fire) begin
				role_q <= role_n; term_q <= term_n; voted_q <= voted_n;
				leader_q <= leader_n; len_q <= len_n; commit_q <= commit_n;
				time_q <= time_n; beat_q <= beat_n; elim_q <= elim_n;
				bt_open_q <= bt_open_n; bt_ok_q <= bt_ok_n; bt_drain_q <= bt_drain_n;
				bt_left_q <= bt_left_n; bt_commit_q <= bt_commit_n;
				bt_to_q <= bt_to_n; bt_pos_q <= bt_pos_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= in_data;
		end
		if (fire && produce) begin
			out_q <= out_n;
		end
	end

	assign out_valid = ov_q;
	assign out_data  = out_q;

endmodule

// ===== verif/tb_raft_consensus_node_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_raft_consensus_node_core: self-checking bench for the Raft node core
// Drives vote requests, append batches, client appends and ticks through the
// valid/ready channels and checks every response beat against a predictor.
// ----------------------------------------------------------------------------
module tb_raft_consensus_node_core;

	localparam int unsigned DEPTH        = rcn_pkg::LOG_DEPTH_DEF;
	localparam logic [2:0]  OP_BAD_FIRST = 3'd5;
	localparam logic [2:0]  OP_BAD_LAST  = 3'd7;
	localparam int          STALL_LIMIT  = 2000;
	localparam int          SETTLE       = 40;
	localparam int          HOLD_CYCLES  = 400;

	class raft_scoreboard;
		logic [15:0]     own_node, tmo_min, tmo_span, hb_ticks;
		logic [1:0]      role;
		logic [31:0]     cur_term;
		logic [15:0]     voted, leader;
		int unsigned     log_len, commit;
		logic [31:0]     log_term_mem[DEPTH];
		logic [31:0]     tick_time, last_beat;
		int unsigned     election_limit;
		bit              bt_open, bt_ok, bt_drain;
		int unsigned     bt_left;
		logic [31:0]     bt_commit;
		logic [15:0]     bt_to;
		longint unsigned bt_pos;
		rcn_pkg::out_t   pending[$];
		int              errors;

		function new();
			own_node = 1; tmo_min = 150; tmo_span = 150; hb_ticks = 50;
			role = rcn_pkg::ROLE_FOLLOWER; cur_term = 0; voted = 0; leader = 0;
			log_len = 0; commit = 0; tick_time = 0; last_beat = 0;
			election_limit = tmo_min;
			bt_open = 0; bt_ok = 0; bt_drain = 0; bt_left = 0;
			bt_commit = 0; bt_to = 0; bt_pos = 0; errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] v);
			case (idx)
				rcn_pkg::REG_OWN_NODE:  own_node = v;
				rcn_pkg::REG_TMO_MIN:   tmo_min = v;
				rcn_pkg::REG_TMO_SPAN:  tmo_span = v;
				rcn_pkg::REG_HEARTBEAT: hb_ticks = v;
				default: begin
				end
			endcase
		endfunction

		function logic [31:0] last_term();
			return (log_len == 0) ? 32'd0 : log_term_mem[log_len - 1];
		endfunction

		function void redraw(logic [15:0] rnd);
			int unsigned off;
			off = (tmo_span != 0) ? rnd % tmo_span : 0;
			election_limit = tmo_min + off;
		endfunction

		function void to_follower(logic [31:0] t, logic [15:0] rnd);
			role = rcn_pkg::ROLE_FOLLOWER; cur_term = t; voted = 0; leader = 0;
			redraw(rnd);
			last_beat = tick_time;
		endfunction

		function void update_commit(logic [31:0] lc);
			if (lc > commit)
				commit = (lc > log_len) ? log_len : lc;
		endfunction

		function void push_resp(logic [1:0] kind, logic [15:0] to, bit ok,
				int unsigned match, logic [1:0] err);
			rcn_pkg::out_t r;
			r.resp_kind = kind; r.resp_to = to; r.resp_term = cur_term;
			r.granted = ok; r.match_len = 11'(match); r.role_now = role;
			r.known_leader = leader; r.commit_now = 11'(commit); r.error_code = err;
			pending.push_back(r);
		endfunction

		function void note_beat(rcn_pkg::in_t b);
			longint unsigned p;
			logic [31:0]     last, elapsed;
			bit              vote_free, log_ok, match, ok, acted;
			if (b.op > rcn_pkg::OP_TICK)
				return;
			if (b.op == rcn_pkg::OP_ENTRY) begin
				if (!bt_open)
					return;
				p = bt_pos;
				if (bt_ok && !bt_drain) begin
					if (p < log_len && log_term_mem[p] != b.entry_term)
						log_len = p[31:0];
					if (p >= log_len) begin
						if (log_len >= DEPTH) begin
							bt_drain = 1;
							bt_left--;
							if (bt_left == 0)
								bt_open = 0;
							push_resp(rcn_pkg::KIND_APPEND, bt_to, 0, 0, rcn_pkg::ERR_LOG_FULL);
							return;
						end
						log_term_mem[log_len] = b.entry_term;
						log_len++;
					end
				end
				bt_pos = p + 1;
				bt_left--;
				if (bt_left != 0)
					return;
				bt_open = 0;
				if (bt_drain)
					return;
				if (bt_ok) begin
					update_commit(bt_commit);
					push_resp(rcn_pkg::KIND_APPEND, bt_to, 1, log_len, rcn_pkg::ERR_OK);
				end else begin
					push_resp(rcn_pkg::KIND_APPEND, bt_to, 0, 0, rcn_pkg::ERR_OK);
				end
				return;
			end
			bt_open = 0;
			case (b.op)
				rcn_pkg::OP_VOTE: begin
					last = last_term();
					if (b.msg_term > cur_term)
						to_follower(b.msg_term, b.random_word);
					vote_free = (voted == 0 || voted == b.sender) && b.msg_term >= cur_term;
					log_ok = b.ref_log_term > last ||
						(b.ref_log_term == last && b.ref_log_index >= log_len);
					ok = 0;
					if (vote_free && log_ok && b.msg_term == cur_term) begin
						voted = b.sender;
						ok = 1;
					end
					push_resp(rcn_pkg::KIND_VOTE, b.sender, ok, 0, rcn_pkg::ERR_OK);
				end
				rcn_pkg::OP_HEADER: begin
					if (b.msg_term > cur_term)
						to_follower(b.msg_term, b.random_word);
					if (b.msg_term == cur_term) begin
						if (role == rcn_pkg::ROLE_CANDIDATE)
							to_follower(b.msg_term, b.random_word);
						leader = b.sender;
						last_beat = tick_time;
					end
					match = (b.ref_log_index == 0) ||
						(b.ref_log_index <= log_len &&
						log_term_mem[b.ref_log_index - 1] == b.ref_log_term);
					ok = (b.msg_term == cur_term) && match;
					if (b.batch_count == 0) begin
						if (ok) begin
							update_commit(b.leader_commit_in);
							push_resp(rcn_pkg::KIND_APPEND, b.sender, 1, log_len,
								rcn_pkg::ERR_OK);
						end else begin
							push_resp(rcn_pkg::KIND_APPEND, b.sender, 0, 0, rcn_pkg::ERR_OK);
						end
					end else begin
						bt_open = 1; bt_ok = ok; bt_drain = 0;
						bt_left = b.batch_count; bt_pos = b.ref_log_index;
						bt_commit = b.leader_commit_in; bt_to = b.sender;
					end
				end
				rcn_pkg::OP_CLIENT: begin
					if (role != rcn_pkg::ROLE_LEADER) begin
						push_resp(rcn_pkg::KIND_CLIENT, 0, 0, 0, rcn_pkg::ERR_NOT_LEADER);
					end else if (log_len >= DEPTH) begin
						push_resp(rcn_pkg::KIND_CLIENT, 0, 0, 0, rcn_pkg::ERR_LOG_FULL);
					end else begin
						log_term_mem[log_len] = cur_term;
						log_len++;
						push_resp(rcn_pkg::KIND_CLIENT, 0, 1, log_len, rcn_pkg::ERR_OK);
					end
				end
				default: begin
					acted = 0;
					tick_time++;
					elapsed = tick_time - last_beat;
					if (role != rcn_pkg::ROLE_LEADER) begin
						if (elapsed > election_limit) begin
							role = rcn_pkg::ROLE_CANDIDATE;
							cur_term++;
							voted = own_node;
							leader = 0;
							redraw(b.random_word);
							last_beat = tick_time;
							acted = 1;
						end
					end else if (elapsed > hb_ticks) begin
						last_beat = tick_time;
						acted = 1;
					end
					push_resp(rcn_pkg::KIND_TICK, 0, acted, 0, rcn_pkg::ERR_OK);
				end
			endcase
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task compare_field(string name, longint unsigned got, longint unsigned want);
			if (got != want)
				report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
		endtask

		task check_beat(rcn_pkg::out_t got);
			rcn_pkg::out_t want;
			if (pending.size() == 0) begin
				report("response beat with none expected");
				return;
			end
			want = pending.pop_front();
			compare_field("resp_kind", got.resp_kind, want.resp_kind);
			compare_field("resp_to", got.resp_to, want.resp_to);
			compare_field("resp_term", got.resp_term, want.resp_term);
			compare_field("granted", got.granted, want.granted);
			compare_field("match_len", got.match_len, want.match_len);
			compare_field("role_now", got.role_now, want.role_now);
			compare_field("known_leader", got.known_leader, want.known_leader);
			compare_field("commit_now", got.commit_now, want.commit_now);
			compare_field("error_code", got.error_code, want.error_code);
		endtask
	endclass

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	rcn_pkg::in_t  in_data;
	logic          out_valid;
	logic          out_ready;
	rcn_pkg::out_t out_data;
	logic          cfg_we;
	logic [1:0]    cfg_index;
	logic [15:0]   cfg_data;

	raft_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_seq;
	int idle_cycles;

	raft_consensus_node_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = rcn_pkg::REG_OWN_NODE;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_seq = 0;
		idle_cycles = 0;
		sb = new();
	end

	always #5 clk = ~clk;

	always begin : receiver
		int seen_seq;
		int hold_left;
		seen_seq = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_seq != seen_seq) begin
				seen_seq = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_beat(out_data);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// All tasks are entered and left at a falling edge.
	task automatic send_beat(rcn_pkg::in_t b);
		if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_beat(b);
		@(negedge clk);
	endtask

	task automatic wait_drained(int extra);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		sb.set_reg(idx, v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(logic [15:0] own, logic [15:0] tmin, logic [15:0] span,
			logic [15:0] hb);
		wait_drained(SETTLE);
		write_reg(rcn_pkg::REG_OWN_NODE, own);
		write_reg(rcn_pkg::REG_TMO_MIN, tmin);
		write_reg(rcn_pkg::REG_TMO_SPAN, span);
		write_reg(rcn_pkg::REG_HEARTBEAT, hb);
	endtask

	function automatic rcn_pkg::in_t noise_beat();
		rcn_pkg::in_t b;
		b.op = rcn_pkg::OP_TICK;
		b.sender = 16'($urandom);
		b.msg_term = $urandom;
		b.ref_log_term = $urandom;
		b.ref_log_index = $urandom;
		b.leader_commit_in = $urandom;
		b.batch_count = 11'($urandom_range(0, 1024));
		b.entry_term = $urandom;
		b.entry_payload = {$urandom, $urandom};
		b.random_word = 16'($urandom);
		return b;
	endfunction

	function automatic rcn_pkg::in_t header_beat(logic [31:0] t, logic [15:0] from,
			logic [31:0] ridx, logic [31:0] rterm, logic [10:0] cnt, logic [31:0] lc);
		rcn_pkg::in_t b;
		b = noise_beat();
		b.op = rcn_pkg::OP_HEADER; b.msg_term = t; b.sender = from;
		b.ref_log_index = ridx; b.ref_log_term = rterm;
		b.batch_count = cnt; b.leader_commit_in = lc;
		return b;
	endfunction

	function automatic rcn_pkg::in_t op_beat(logic [2:0] op);
		rcn_pkg::in_t b;
		b = noise_beat();
		b.op = op;
		return b;
	endfunction

	task automatic send_entry(logic [31:0] t);
		rcn_pkg::in_t b;
		b = op_beat(rcn_pkg::OP_ENTRY);
		b.entry_term = t;
		send_beat(b);
	endtask

	task automatic send_vote(logic [31:0] t, logic [15:0] from, logic [31:0] rterm,
			logic [31:0] ridx);
		rcn_pkg::in_t b;
		b = op_beat(rcn_pkg::OP_VOTE);
		b.msg_term = t; b.sender = from; b.ref_log_term = rterm; b.ref_log_index = ridx;
		send_beat(b);
	endtask

	task automatic directed_part();
		send_beat(op_beat(rcn_pkg::OP_TICK));
		send_vote(1, 5, 0, 0);
		send_vote(1, 6, 0, 0);
		send_beat(header_beat(1, 7, 0, 0, 0, 0));
		send_beat(header_beat(1, 7, 0, 0, 3, 32'hFFFF_FFFF));
		repeat (3) send_entry(1);
		send_beat(header_beat(1, 7, 5, 1, 2, 1));
		repeat (2) send_entry(1);
		send_entry(1);
		send_beat(op_beat(OP_BAD_LAST));
		send_beat(op_beat(OP_BAD_FIRST));
		send_beat(header_beat(1, 7, 3, 1, 4, 2));
		send_entry(1);
		send_vote(0, 8, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_beat(op_beat(rcn_pkg::OP_CLIENT));
		send_beat(header_beat(1, 16'hFFFF, 1, 1, 1, 2));
		send_entry(2);

		set_config(16'hFFFF, 16'd1, 16'd1, 16'd1);
		send_vote(32'hFFFF_FFFF, 9, 32'hFFFF_FFFF, 0);
		repeat (3) send_beat(op_beat(rcn_pkg::OP_TICK));
		send_beat(header_beat(sb.cur_term, 3, 0, 0, 11'd1023, 0));
		send_beat(op_beat(rcn_pkg::OP_TICK));

		// Fill the log completely, then overrun it.
		send_beat(header_beat(sb.cur_term, 3, 0, 0, 11'd1024, 32'd1024));
		repeat (DEPTH) send_entry(sb.cur_term ^ {31'd0, $urandom_range(0, 3) == 0});
		send_beat(header_beat(sb.cur_term, 3, DEPTH, sb.last_term(), 2, 0));
		repeat (2) send_entry(sb.cur_term);
		send_beat(header_beat(sb.cur_term, 3, DEPTH, sb.last_term(), 0, 0));
		send_beat(op_beat(rcn_pkg::OP_CLIENT));
		send_vote(sb.cur_term + 1, 4, sb.last_term(), DEPTH);
		send_beat(header_beat(sb.cur_term, 3, 0, 0, 1, 0));
		send_entry(~sb.log_term_mem[0]);
	endtask

	function automatic logic [31:0] pick_term();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return $urandom;
		if (r < 12)
			return sb.cur_term - 1;
		return sb.cur_term + $urandom_range(0, 1);
	endfunction

	task automatic random_phase(int n_items, bit pause_mid);
		rcn_pkg::in_t b;
		int sent, pick, k;
		logic [31:0] t, ridx;
		sent = 0;
		while (sent < n_items) begin
			if (pause_mid && sent >= n_items / 2) begin
				pause_mid = 0;
				set_config(16'($urandom_range(1, 65535)), 16'hFFFF,
					16'($urandom_range(1, 9)), 16'd1);
			end
			pick = $urandom_range(0, 99);
			b = noise_beat();
			if (pick < 40) begin
				t = pick_term();
				if ($urandom_range(0, 9) < 8) begin
					ridx = $urandom_range(0, sb.log_len);
					b.ref_log_term = (ridx == 0) ? $urandom : sb.log_term_mem[ridx - 1];
				end else begin
					ridx = ($urandom_range(0, 1) == 0) ? $urandom : sb.log_len + 1;
				end
				b.op = rcn_pkg::OP_HEADER; b.msg_term = t; b.ref_log_index = ridx;
				b.sender = 16'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(1, 4));
				b.batch_count = 11'($urandom_range(0, 9) == 0 ?
					$urandom_range(0, 1024) : $urandom_range(0, 5));
				if ($urandom_range(0, 9) != 0)
					b.leader_commit_in = $urandom_range(0, sb.log_len + 8);
				k = b.batch_count;
				if (k > 6 || $urandom_range(0, 19) == 0)
					k = $urandom_range(0, 6 < k ? 6 : k);
				send_beat(b);
				sent++;
				repeat (k) begin
					if (sb.bt_pos < sb.log_len && $urandom_range(0, 3) != 0)
						send_entry(sb.log_term_mem[sb.bt_pos]);
					else
						send_entry($urandom_range(0, 19) == 0 ? $urandom : t);
					sent++;
				end
			end else if (pick < 60) begin
				b.op = rcn_pkg::OP_VOTE;
				b.msg_term = pick_term();
				b.sender = 16'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(1, 4));
				b.ref_log_term = sb.last_term() + $urandom_range(0, 2) - 1;
				b.ref_log_index = sb.log_len + $urandom_range(0, 2) - 1;
				send_beat(b);
				sent++;
			end else if (pick < 88) begin
				b.op = rcn_pkg::OP_TICK;
				send_beat(b);
				sent++;
			end else if (pick < 92) begin
				b.op = rcn_pkg::OP_CLIENT;
				send_beat(b);
				sent++;
			end else if (pick < 96) begin
				b.op = rcn_pkg::OP_ENTRY;
				send_beat(b);
			end else begin
				b.op = 3'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
				send_beat(b);
			end
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed_part();

		set_config(16'hFFFF, 16'd1, 16'd7, 16'd1);
		send_idle_pct = 12;
		recv_idle_pct = 51;
		random_phase(90, 0);

		set_config(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 30)), 16'hFFFF,
			16'hFFFF);
		send_idle_pct = 51;
		recv_idle_pct = 12;
		hold_seq++;
		random_phase(90, 0);

		set_config(16'd1, 16'd3, 16'd1, 16'($urandom_range(1, 65535)));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(95, 1);

		wait_drained(SETTLE);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/rcn_pkg.sv
rtl/rcn_mod.sv
rtl/rcn_log_mem.sv
rtl/raft_consensus_node_core.sv
verif/tb_raft_consensus_node_core.sv
